FILE: sv/stsd_pkg.sv
package stsd_pkg;

  // width of the subdivision depth register and of the depth tag of an item
  localparam int unsigned DEPTH_W = 2;

  // midpoint sums are brought below this many bits before squaring
  localparam int unsigned PRESCALE_BITS = 18;

  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // vertex slots of one subdivision frame
  localparam int unsigned SLOT_A  = 0;
  localparam int unsigned SLOT_B  = 1;
  localparam int unsigned SLOT_C  = 2;
  localparam int unsigned SLOT_AB = 3;
  localparam int unsigned SLOT_AC = 4;
  localparam int unsigned SLOT_BC = 5;
  localparam int unsigned SLOTS   = 6;

  // child order of a split triangle
  localparam logic [1:0] CHILD_A      = 2'd0;
  localparam logic [1:0] CHILD_B      = 2'd1;
  localparam logic [1:0] CHILD_C      = 2'd2;
  localparam logic [1:0] CHILD_CENTRE = 2'd3;

  // which edge the midpoint unit works on
  localparam logic [1:0] MID_AB = 2'd0;
  localparam logic [1:0] MID_AC = 2'd1;
  localparam logic [1:0] MID_BC = 2'd2;

  typedef enum logic [1:0] {
    W_IDLE,
    W_MSTART,
    W_MWAIT,
    W_EMIT
  } walk_state_e;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SHIFT,
    M_SQ,
    M_SQRT,
    M_DIVLD,
    M_DIV,
    M_DONE
  } mid_state_e;

endpackage

FILE: sv/stsd_front.sv
module stsd_front #(
  parameter int unsigned MAX_DEPTH = 3,
  parameter int unsigned TRI_W     = 144
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [TRI_W-1:0]             tri_i,
  input  logic [stsd_pkg::DEPTH_W-1:0] depth_i,
  output logic                         q_valid_o,
  input  logic                         q_pop_i,
  output logic [TRI_W-1:0]             q_tri_o,
  output logic [stsd_pkg::DEPTH_W-1:0] q_depth_o
);
  import stsd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [TRI_W-1:0]   data_q [QUEUE_DEPTH];
  logic [DEPTH_W-1:0] dep_q  [QUEUE_DEPTH];
  logic [PW-1:0]      wr_q, rd_q;
  logic [CNTW-1:0]    cnt_q;
  logic               wr_en, rd_en;
  logic [DEPTH_W-1:0] depth_sat;

  // depth is clamped once, at intake
  assign depth_sat = (depth_i > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth_i;

  assign full_o    = (cnt_q == CNTW'(QUEUE_DEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign wr_en     = push_i && !full_o;
  assign rd_en     = q_pop_i && q_valid_o;
  assign q_tri_o   = data_q[rd_q];
  assign q_depth_o = dep_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + PW'(1);
      if (rd_en) rd_q <= rd_q + PW'(1);
      if (wr_en && !rd_en) cnt_q <= cnt_q + CNTW'(1);
      else if (rd_en && !wr_en) cnt_q <= cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      data_q[wr_q] <= tri_i;
      dep_q[wr_q]  <= depth_sat;
    end
  end

endmodule

FILE: sv/stsd_midpoint.sv
module stsd_midpoint #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [3*COORD_WIDTH-1:0]   u_i,
  input  logic [3*COORD_WIDTH-1:0]   v_i,
  output logic                       done_o,
  output logic [3*COORD_WIDTH-1:0]   m_o
);
  import stsd_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned MW    = CW + 1;
  localparam int unsigned SW    = (MW < PRESCALE_BITS) ? MW : PRESCALE_BITS;
  localparam int unsigned SUMW  = 2 * SW + 2;
  localparam int unsigned RW    = SW + 1;
  localparam int unsigned QB    = CW - 1;
  localparam int unsigned NW    = SW + QB + 1;
  localparam int unsigned DW    = RW + 1;
  localparam int unsigned CMAX  = (QB > RW) ? QB : RW;
  localparam int unsigned CNT_W = $clog2(CMAX);
  localparam int unsigned SQ_LAST = 3;

  mid_state_e state_q, state_d;

  logic [MW-1:0]    mag_q [3];
  logic             neg_q [3];
  logic [2*SW-1:0]  sq_q;
  logic [SUMW-1:0]  sum_q, sum_fin, rad_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       comp_q;
  logic [RW-1:0]    root_q;
  logic [RW:0]      srem_q;
  logic [DW-1:0]    drem_q;
  logic [QB-1:0]    num_q, quo_q, q_fin;
  logic [CW-1:0]    res_q [3];

  logic             big;
  logic [SW-1:0]    sq_sel;
  logic [RW+2:0]    cand_s, trial_s;
  logic             take_s;
  logic [MW-1:0]    mag_c;
  logic             neg_c;
  logic [NW-1:0]    num_full;
  logic [DW:0]      cand_d, div_d;
  logic             qbit;
  logic [CW-1:0]    res_val;
  logic             sq_end, sqrt_end, div_end;

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((mag_q[i] >> SW) != '0) big = 1'b1;
    end
  end

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_sel = mag_q[0][SW-1:0];
      2'd1:    sq_sel = mag_q[1][SW-1:0];
      2'd2:    sq_sel = mag_q[2][SW-1:0];
      default: sq_sel = '0;
    endcase
  end

  assign sum_fin = sum_q + SUMW'(sq_q);

  // one root bit per cycle, two radicand bits in
  assign cand_s  = {srem_q, rad_q[SUMW-1 -: 2]};
  assign trial_s = (RW+3)'({root_q, 2'b01});
  assign take_s  = (cand_s >= trial_s);

  always_comb begin
    case (comp_q)
      MID_AB:  begin mag_c = mag_q[0]; neg_c = neg_q[0]; end
      MID_AC:  begin mag_c = mag_q[1]; neg_c = neg_q[1]; end
      default: begin mag_c = mag_q[2]; neg_c = neg_q[2]; end
    endcase
  end

  // numerator gets +r so that the quotient rounds half away from zero
  assign num_full = (NW'(mag_c[SW-1:0]) << QB) + NW'(root_q);
  assign cand_d   = {drem_q, num_q[QB-1]};
  assign div_d    = (DW+1)'({root_q, 1'b0});
  assign qbit     = (cand_d >= div_d);
  assign q_fin    = {quo_q[QB-2:0], qbit};
  assign res_val  = neg_c ? (CW'(0) - CW'(q_fin)) : CW'(q_fin);

  assign sq_end   = (cnt_q == CNT_W'(SQ_LAST));
  assign sqrt_end = (cnt_q == CNT_W'(RW - 1));
  assign div_end  = (cnt_q == CNT_W'(QB - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE:  if (start_i) state_d = M_SHIFT;
      M_SHIFT: if (!big) state_d = M_SQ;
      M_SQ:    if (sq_end) state_d = (sum_fin == '0) ? M_DONE : M_SQRT;
      M_SQRT:  if (sqrt_end) state_d = M_DIVLD;
      M_DIVLD: state_d = M_DIV;
      M_DIV:   if (div_end) state_d = (comp_q == MID_BC) ? M_DONE : M_DIVLD;
      M_DONE:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == M_DONE);
    m_o    = {res_q[2], res_q[1], res_q[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= M_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            logic signed [MW-1:0] s;
            s = MW'($signed(u_i[i*CW +: CW])) + MW'($signed(v_i[i*CW +: CW]));
            neg_q[i] <= s[MW-1];
            mag_q[i] <= s[MW-1] ? (MW'(0) - MW'(s)) : MW'(s);
          end
        end
      end
      M_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else begin
          cnt_q <= '0;
          sum_q <= '0;
        end
      end
      M_SQ: begin
        if (cnt_q != '0) sum_q <= sum_fin;
        if (!sq_end) begin
          sq_q  <= sq_sel * sq_sel;
          cnt_q <= cnt_q + CNT_W'(1);
        end else begin
          rad_q  <= sum_fin;
          root_q <= '0;
          srem_q <= '0;
          cnt_q  <= '0;
          for (int i = 0; i < 3; i++) res_q[i] <= '0;
        end
      end
      M_SQRT: begin
        srem_q <= take_s ? (RW+1)'(cand_s - trial_s) : (RW+1)'(cand_s);
        root_q <= {root_q[RW-2:0], take_s};
        rad_q  <= rad_q << 2;
        cnt_q  <= cnt_q + CNT_W'(1);
        if (sqrt_end) comp_q <= MID_AB;
      end
      M_DIVLD: begin
        drem_q <= DW'(num_full >> QB);
        num_q  <= num_full[QB-1:0];
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      M_DIV: begin
        drem_q <= qbit ? DW'(cand_d - div_d) : DW'(cand_d);
        num_q  <= num_q << 1;
        quo_q  <= q_fin;
        cnt_q  <= cnt_q + CNT_W'(1);
        if (div_end) begin
          case (comp_q)
            MID_AB:  res_q[0] <= res_val;
            MID_AC:  res_q[1] <= res_val;
            default: res_q[2] <= res_val;
          endcase
          comp_q <= comp_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/stsd_walker.sv
module stsd_walker #(
  parameter int unsigned MAX_DEPTH   = 3,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  logic [9*COORD_WIDTH-1:0]     q_tri_i,
  input  logic [stsd_pkg::DEPTH_W-1:0] q_depth_i,
  output logic                         out_valid_o,
  input  logic                         out_pop_i,
  output logic [9*COORD_WIDTH-1:0]     out_tri_o,
  output logic                         out_last_o
);
  import stsd_pkg::*;

  localparam int unsigned VW    = 3 * COORD_WIDTH;
  localparam int unsigned TW    = 3 * VW;
  localparam int unsigned FRW   = SLOTS * VW;
  localparam int unsigned LVL_W = (MAX_DEPTH > 1) ? 2 : 1;
  localparam int unsigned FR    = (MAX_DEPTH > 0) ? MAX_DEPTH : 1;
  localparam int unsigned FW    = (FR > 1) ? $clog2(FR) : 1;

  walk_state_e state_d, state_q;

  logic [TW-1:0]    tri_q;
  logic [LVL_W-1:0] lev_q, depth_q;
  logic [1:0]       ms_q;
  logic [FRW-1:0]   frame_q [FR];
  logic [1:0]       cidx_q  [FR];
  logic             out_valid_q, out_last_q;
  logic [TW-1:0]    out_tri_q;

  logic [VW-1:0]    mu, mv, mres;
  logic             mid_start, mid_done;
  logic             slot_free, emit;
  logic             asc_found;
  logic [FW-1:0]    asc_idx, cur_idx;

  function automatic logic [TW-1:0] child_of(input logic [FRW-1:0] f, input logic [1:0] k);
    logic [VW-1:0] a, b, c, ab, ac, bc;
    logic [TW-1:0] r;
    a  = f[SLOT_A*VW  +: VW];
    b  = f[SLOT_B*VW  +: VW];
    c  = f[SLOT_C*VW  +: VW];
    ab = f[SLOT_AB*VW +: VW];
    ac = f[SLOT_AC*VW +: VW];
    bc = f[SLOT_BC*VW +: VW];
    case (k)
      CHILD_A: r = {ac, ab, a};
      CHILD_B: r = {ab, bc, b};
      CHILD_C: r = {bc, ac, c};
      default: r = {ac, bc, ab};   // centre
    endcase
    return r;
  endfunction

  always_comb begin
    case (ms_q)
      MID_AB:  begin mu = tri_q[0 +: VW];  mv = tri_q[VW +: VW];   end
      MID_AC:  begin mu = tri_q[0 +: VW];  mv = tri_q[2*VW +: VW]; end
      default: begin mu = tri_q[VW +: VW]; mv = tri_q[2*VW +: VW]; end
    endcase
  end

  stsd_midpoint #(.COORD_WIDTH(COORD_WIDTH)) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mid_start),
    .u_i     (mu),
    .v_i     (mv),
    .done_o  (mid_done),
    .m_o     (mres)
  );

  // after a leaf, resume at the nearest ancestor that still has children left
  always_comb begin
    asc_found = 1'b0;
    asc_idx   = '0;
    for (int r = MAX_DEPTH; r >= 1; r--) begin
      if (LVL_W'(r) <= depth_q && cidx_q[r-1] != CHILD_CENTRE) begin
        asc_found = 1'b1;
        asc_idx   = FW'(r - 1);
      end
    end
  end

  assign cur_idx   = FW'(lev_q - LVL_W'(1));
  assign slot_free = !out_valid_q || out_pop_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE: begin
        if (q_valid_i) state_d = (q_depth_i == '0) ? W_EMIT : W_MSTART;
      end
      W_MSTART: state_d = W_MWAIT;
      W_MWAIT: begin
        if (mid_done) begin
          if (ms_q == MID_BC && lev_q == LVL_W'(1)) state_d = W_EMIT;
          else                                      state_d = W_MSTART;
        end
      end
      W_EMIT: begin
        if (slot_free) begin
          if (!asc_found)              state_d = W_IDLE;
          else if (asc_idx == '0)      state_d = W_EMIT;
          else                         state_d = W_MSTART;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = (state_q == W_IDLE) && q_valid_i;
    mid_start = (state_q == W_MSTART);
    emit      = (state_q == W_EMIT) && slot_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_tri_o   = out_tri_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= W_IDLE;
      out_valid_q <= 1'b0;
      ms_q        <= MID_AB;
    end else begin
      state_q <= state_d;
      if (emit)           out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
      if (state_q == W_MWAIT && mid_done) begin
        ms_q <= (ms_q == MID_BC) ? MID_AB : ms_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      tri_q   <= q_tri_i;
      lev_q   <= LVL_W'(q_depth_i);
      depth_q <= LVL_W'(q_depth_i);
    end
    if (state_q == W_MWAIT && mid_done) begin
      // first midpoint also latches the corners of the frame
      if (ms_q == MID_AB) frame_q[cur_idx][0 +: 4*VW] <= {mres, tri_q};
      else frame_q[cur_idx][(SLOT_AB + 32'(ms_q))*VW +: VW] <= mres;
      if (ms_q == MID_BC) begin
        cidx_q[cur_idx] <= CHILD_A;
        tri_q <= {frame_q[cur_idx][SLOT_AC*VW +: VW],
                  frame_q[cur_idx][SLOT_AB*VW +: VW],
                  tri_q[0 +: VW]};
        lev_q <= lev_q - LVL_W'(1);
      end
    end
    if (emit) begin
      out_tri_q  <= tri_q;
      out_last_q <= !asc_found;
      if (asc_found) begin
        cidx_q[asc_idx] <= cidx_q[asc_idx] + 2'd1;
        tri_q <= child_of(frame_q[asc_idx], cidx_q[asc_idx] + 2'd1);
        lev_q <= LVL_W'(asc_idx);
      end
    end
  end

endmodule

FILE: sv/sphere_triangle_subdivider.sv
// Icosphere midpoint subdivision of one triangle per item.
// Input side is a queue: drive the nine vertex coordinates (Q2.14) with push;
// the item is taken on a clock edge with push high and full low. Up to two
// items wait in the intake queue while the back end works.
// Result side is a queue too: while empty is low the oldest leaf triangle is
// on p*_o, components in z, y, x order; pop takes it. last_leaf_o marks the
// final leaf of an item. A stalled receiver just holds the leaf register and
// the walker waits; nothing is dropped.
// subdivision_depth_i is written with subdivision_depth_we_i, resets to 1 and
// is clamped to MAX_DEPTH when an item is taken.
// Each split triangle runs its AB, AC and BC edge midpoints through a single
// shared normalizer (prescale, three squares, a bit-serial square root and
// three bit-serial divides). Reset empties both queues and the walker.
module sphere_triangle_subdivider #(
  parameter int unsigned MAX_DEPTH   = 3,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_z_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_z_i,
  input  logic signed [COORD_WIDTH-1:0] c_x_i,
  input  logic signed [COORD_WIDTH-1:0] c_y_i,
  input  logic signed [COORD_WIDTH-1:0] c_z_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_WIDTH-1:0] p0_first_o,
  output logic signed [COORD_WIDTH-1:0] p0_second_o,
  output logic signed [COORD_WIDTH-1:0] p0_third_o,
  output logic signed [COORD_WIDTH-1:0] p1_first_o,
  output logic signed [COORD_WIDTH-1:0] p1_second_o,
  output logic signed [COORD_WIDTH-1:0] p1_third_o,
  output logic signed [COORD_WIDTH-1:0] p2_first_o,
  output logic signed [COORD_WIDTH-1:0] p2_second_o,
  output logic signed [COORD_WIDTH-1:0] p2_third_o,
  output logic                          last_leaf_o,
  input  logic                          subdivision_depth_we_i,
  input  logic [stsd_pkg::DEPTH_W-1:0]  subdivision_depth_i
);
  import stsd_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned VW = 3 * CW;
  localparam int unsigned TW = 3 * VW;

  logic [DEPTH_W-1:0] depth_cfg_q;
  logic [TW-1:0]      in_tri, q_tri, out_tri;
  logic [DEPTH_W-1:0] q_depth;
  logic               q_valid, q_pop, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                     depth_cfg_q <= DEPTH_W'(1);
    else if (subdivision_depth_we_i) depth_cfg_q <= subdivision_depth_i;
  end

  assign in_tri = {c_z_i, c_y_i, c_x_i, b_z_i, b_y_i, b_x_i, a_z_i, a_y_i, a_x_i};

  stsd_front #(.MAX_DEPTH(MAX_DEPTH), .TRI_W(TW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .tri_i     (in_tri),
    .depth_i   (depth_cfg_q),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_tri_o   (q_tri),
    .q_depth_o (q_depth)
  );

  stsd_walker #(.MAX_DEPTH(MAX_DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_tri_i     (q_tri),
    .q_depth_i   (q_depth),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .out_tri_o   (out_tri),
    .out_last_o  (last_leaf_o)
  );

  assign empty = !out_valid;

  // components leave in z, y, x order
  assign p0_first_o  = out_tri[0*VW + 2*CW +: CW];
  assign p0_second_o = out_tri[0*VW + 1*CW +: CW];
  assign p0_third_o  = out_tri[0*VW + 0*CW +: CW];
  assign p1_first_o  = out_tri[1*VW + 2*CW +: CW];
  assign p1_second_o = out_tri[1*VW + 1*CW +: CW];
  assign p1_third_o  = out_tri[1*VW + 0*CW +: CW];
  assign p2_first_o  = out_tri[2*VW + 2*CW +: CW];
  assign p2_second_o = out_tri[2*VW + 1*CW +: CW];
  assign p2_third_o  = out_tri[2*VW + 0*CW +: CW];

endmodule
